// ===== design/ibrp_pkg.sv =====
package ibrp_pkg;

  // Field widths.
  localparam int PIX_W    = 16;
  localparam int COORD_W  = 16;
  localparam int CNT_W    = 14;
  localparam int DIM_W    = 15;
  localparam int BORDER_W = 3;
  localparam int CFG_IDX_W = 2;

  // Image size limits.
  localparam int MaxWidth  = 16384;
  localparam int MaxHeight = 16384;
  localparam int MinDim    = 2;

  // Descriptor queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_BORDER_WIDTH = 2'd2
  } cfg_index_t;

  // One pixel's work: its value and the rectangle of positions it covers.
  typedef struct packed {
    logic signed [PIX_W-1:0]   value;
    logic signed [COORD_W-1:0] x_lo;
    logic signed [COORD_W-1:0] x_hi;
    logic signed [COORD_W-1:0] y_lo;
    logic signed [COORD_W-1:0] y_hi;
  } desc_t;

  // Queue status seen by the front end and the checks.
  typedef struct packed {
    logic              full;
    logic              valid;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

  // Back end status.
  typedef struct packed {
    logic busy;
  } back_stat_t;

  // Saturate a dimension to its legal range and return the last index.
  function automatic logic [CNT_W-1:0] last_index(input logic [DIM_W-1:0] dim, input int lim);
    logic [DIM_W-1:0] sat;
    begin
      if (dim < DIM_W'(MinDim)) begin
        sat = DIM_W'(MinDim);
      end else if (dim > DIM_W'(lim)) begin
        sat = DIM_W'(lim);
      end else begin
        sat = dim;
      end
      last_index = CNT_W'(sat - DIM_W'(1));
    end
  endfunction

endpackage

// ===== design/ibrp_pix_if.sv =====
interface ibrp_pix_if import ibrp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

// ===== design/ibrp_res_if.sv =====
interface ibrp_res_if import ibrp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [PIX_W-1:0]   out_value;
  logic                      run_last;

  modport source (output valid, output out_x, output out_y, output out_value,
                  output run_last, input ready);
  modport sink (input valid, input out_x, input out_y, input out_value,
                input run_last, output ready);
endinterface

// ===== design/ibrp_cfg_if.sv =====
interface ibrp_cfg_if import ibrp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/image_border_replicate_padder.sv =====
// Edge-replicate border padder. Pixels arrive in raster order on the pixel
// channel; each one leaves as a run of words on the result channel: its own
// position, plus every border position it is nearest to, in ascending rows and
// columns, with run_last set on the final word. An interior pixel gives 1
// word, an edge pixel border_width+1 words and a corner pixel
// (border_width+1)^2 words; the back-end emitter produces one word per cycle
// while the sink takes them. A four-entry descriptor queue lets the front
// keep taking pixels while the emitter works through an edge run. A pixel
// taken by an idle block passes the queue and the item register to the
// output register. Any configuration write to a valid index restarts the
// frame at column 0, row 0; a pixel is not taken in a cycle with a pending
// configuration word; write configuration only while the block is idle.
module image_border_replicate_padder import ibrp_pkg::*; (
  input logic         clk,
  input logic         rst,
  ibrp_pix_if.sink    pixel,
  ibrp_cfg_if.sink    cfg,
  ibrp_res_if.source  result
);

  logic        push;
  desc_t       push_data;
  logic        pop;
  desc_t       pop_data;
  queue_stat_t q_stat;
  back_stat_t  b_stat;

  // Front end: counters, configuration and edge classification.
  ibrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Descriptor queue.
  ibrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // Back end: emits the words of each descriptor.
  ibrp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .q_data (pop_data),
    .pop    (pop),
    .stat   (b_stat),
    .result (result)
  );

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("descriptor queue overfilled");

  // A new result word only comes from an item the back end holds.
  a_word_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(b_stat.busy))
    else $error("result word without a loaded item");

  // A pixel accepted into an empty, idle design is picked up at once.
  a_prompt_load: assert property (@(posedge clk) disable iff (rst)
    (push && !q_stat.valid && !b_stat.busy) |-> ##2 b_stat.busy)
    else $error("back end did not load a waiting item");

  // Nothing is popped from an empty queue.
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.valid)
    else $error("pop from empty queue");

endmodule

// ===== design/ibrp_queue.sv =====
module ibrp_queue import ibrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  desc_t       push_data,
  input  logic        pop,
  output desc_t       pop_data,
  output queue_stat_t stat
);

  desc_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.valid = (count != '0);
  assign stat.count = count;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign pop_data   = entries[rd_ptr];

  // Storage is written only at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/ibrp_front.sv =====
module ibrp_front import ibrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ibrp_pix_if.sink    pixel,
  ibrp_cfg_if.sink    cfg,
  input  queue_stat_t q_stat,
  output logic        push,
  output desc_t       push_data
);

  logic [CNT_W-1:0]    column_count;
  logic [CNT_W-1:0]    row_count;
  logic [CNT_W-1:0]    last_col;
  logic [CNT_W-1:0]    last_row;
  logic [BORDER_W-1:0] border;
  logic                at_right;
  logic                at_bottom;
  logic                cfg_write;
  logic signed [COORD_W-1:0] bext;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;

  // A pending configuration word goes first, so a pixel never shares its edge.
  assign pixel.ready = !q_stat.full && !cfg.valid;
  assign cfg.ready   = 1'b1;
  assign push        = pixel.valid && pixel.ready;
  assign cfg_write   = cfg.valid && cfg.ready;

  assign at_right  = (column_count == last_col);
  assign at_bottom = (row_count == last_row);
  assign bext      = COORD_W'(border);
  assign cx        = COORD_W'(column_count);
  assign cy        = COORD_W'(row_count);

  // Classify the pixel by the edges it lies on and build its rectangle.
  always_comb begin
    push_data.value = pixel.pixel_value;
    push_data.x_lo  = (column_count == '0) ? -bext : cx;
    push_data.x_hi  = at_right ? (cx + bext) : cx;
    push_data.y_lo  = (row_count == '0) ? -bext : cy;
    push_data.y_hi  = at_bottom ? (cy + bext) : cy;
  end

  // Configuration registers and raster counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_col     <= last_index(DIM_W'(352), MaxWidth);
      last_row     <= last_index(DIM_W'(288), MaxHeight);
      border       <= BORDER_W'(4);
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_write) begin
      unique case (cfg.index)
        CFG_FRAME_WIDTH: begin
          last_col     <= last_index(cfg.data, MaxWidth);
          column_count <= '0;
          row_count    <= '0;
        end
        CFG_FRAME_HEIGHT: begin
          last_row     <= last_index(cfg.data, MaxHeight);
          column_count <= '0;
          row_count    <= '0;
        end
        CFG_BORDER_WIDTH: begin
          border       <= cfg.data[BORDER_W-1:0];
          column_count <= '0;
          row_count    <= '0;
        end
        default: begin
        end
      endcase
    end else if (push) begin
      if (at_right) begin
        column_count <= '0;
        row_count    <= at_bottom ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/ibrp_back.sv =====
module ibrp_back import ibrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_stat_t q_stat,
  input  desc_t       q_data,
  output logic        pop,
  output back_stat_t  stat,
  ibrp_res_if.source  result
);

  desc_t                     item;
  logic                      busy;
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic                      can_emit;
  logic                      emit;
  logic                      row_end;
  logic                      at_last;

  assign can_emit  = !result.valid || result.ready;
  assign emit      = busy && can_emit;
  assign row_end   = (cur_x == item.x_hi);
  assign at_last   = row_end && (cur_y == item.y_hi);
  assign pop       = q_stat.valid && (!busy || (emit && at_last));
  assign stat.busy = busy;

  // Walk the rectangle row by row, one position per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (emit && at_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item  <= q_data;
      cur_x <= q_data.x_lo;
      cur_y <= q_data.y_lo;
    end else if (emit && !at_last) begin
      if (row_end) begin
        cur_x <= item.x_lo;
        cur_y <= cur_y + COORD_W'(1);
      end else begin
        cur_x <= cur_x + COORD_W'(1);
      end
    end
  end

  // Output register: holds a word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.out_x     <= cur_x;
      result.out_y     <= cur_y;
      result.out_value <= item.value;
      result.run_last  <= at_last;
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb import ibrp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXEL_TARGET = 470;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES = 12;
  localparam int STUCK_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  // One word of the padded frame as it should leave the block.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [PIX_W-1:0]   value;
    logic                      last;
  } pad_word_t;

  // One pending item: either a register write or a pixel.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     data;
    logic signed [PIX_W-1:0] pix;
    bit                   src_idle;
    bit                   sink_idle;
  } pend_item_t;

  logic clk = 1'b0;
  logic rst;

  ibrp_pix_if pixel ();
  ibrp_cfg_if cfg ();
  ibrp_res_if result ();

  image_border_replicate_padder dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .cfg    (cfg),
    .result (result)
  );

  pend_item_t pend_items[$];
  pad_word_t  due_words[$];

  // Mirror of the block's geometry registers and raster position.
  logic [DIM_W-1:0]    geo_w;
  logic [DIM_W-1:0]    geo_h;
  logic [BORDER_W-1:0] geo_b;
  int col_pos;
  int row_pos;

  int items_total = 0;
  int items_done = 0;
  int pixels_queued = 0;
  int phases = 0;
  int words_checked = 0;
  int err_count = 0;
  int settle_cnt = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int stuck_cycles = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Most gaps are short; now and then a long one.
  function automatic int next_gap(bit en);
    if (!en || $urandom_range(0, 2) != 0) begin
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // A write to a known register also restarts the frame.
  function automatic void write_geometry(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    case (idx)
      CFG_FRAME_WIDTH: begin
        geo_w = data;
      end
      CFG_FRAME_HEIGHT: begin
        geo_h = data;
      end
      CFG_BORDER_WIDTH: begin
        geo_b = data[BORDER_W-1:0];
      end
      default: begin
        return;
      end
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Expand one pixel into its own position plus the border positions it covers.
  function automatic void replicate_pixel(logic signed [PIX_W-1:0] value);
    int w, h, b, xl, xh, yl, yh;
    pad_word_t wd;
    w = (geo_w < MinDim) ? MinDim : (geo_w > MaxWidth) ? MaxWidth : int'(geo_w);
    h = (geo_h < MinDim) ? MinDim : (geo_h > MaxHeight) ? MaxHeight : int'(geo_h);
    b = geo_b;
    if (col_pos >= w) begin
      col_pos = 0;
    end
    if (row_pos >= h) begin
      row_pos = 0;
    end
    xl = (col_pos == 0) ? -b : col_pos;
    xh = (col_pos == w - 1) ? col_pos + b : col_pos;
    yl = (row_pos == 0) ? -b : row_pos;
    yh = (row_pos == h - 1) ? row_pos + b : row_pos;
    for (int y = yl; y <= yh; y++) begin
      for (int x = xl; x <= xh; x++) begin
        wd.x = COORD_W'(x);
        wd.y = COORD_W'(y);
        wd.value = value;
        wd.last = (y == yh) && (x == xh);
        due_words.push_back(wd);
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
      end
    end
  endfunction

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data, bit si, bit ki);
    pend_item_t it;
    it.is_cfg = 1'b1;
    it.idx = idx;
    it.data = data;
    it.pix = '0;
    it.src_idle = si;
    it.sink_idle = ki;
    pend_items.push_back(it);
    items_total++;
  endtask

  task automatic add_pixel(logic signed [PIX_W-1:0] v);
    pend_item_t it;
    it.is_cfg = 1'b0;
    it.idx = CFG_NONE;
    it.data = '0;
    it.pix = v;
    it.src_idle = 1'b0;
    it.sink_idle = 1'b0;
    pend_items.push_back(it);
    items_total++;
    pixels_queued++;
  endtask

  // Driver: feeds pixels and register writes, predicting at each acceptance.
  // A register write waits until the block has drained and settled.
  always @(posedge clk) begin : drive
    pend_item_t head;
    logic pix_hold, cfg_hold;
    if (rst) begin
      pixel.valid <= 1'b0;
      cfg.valid <= 1'b0;
      settle_cnt = 0;
      src_gap = 0;
    end else begin
      pix_hold = pixel.valid && !pixel.ready;
      cfg_hold = cfg.valid && !cfg.ready;
      if (pixel.valid && pixel.ready) begin
        replicate_pixel(pixel.pixel_value);
        items_done++;
      end
      if (cfg.valid && cfg.ready) begin
        write_geometry(cfg.index, cfg.data);
        items_done++;
      end
      if (due_words.size() == 0 && !pixel.valid && !cfg.valid) begin
        settle_cnt++;
      end else begin
        settle_cnt = 0;
      end
      if (!pix_hold && !cfg_hold) begin
        if (src_gap > 0) begin
          src_gap--;
          pixel.valid <= 1'b0;
          cfg.valid <= 1'b0;
        end else if (pend_items.size() == 0) begin
          pixel.valid <= 1'b0;
          cfg.valid <= 1'b0;
        end else if (pend_items[0].is_cfg) begin
          pixel.valid <= 1'b0;
          if (settle_cnt >= SETTLE_CYCLES) begin
            head = pend_items.pop_front();
            cfg.valid <= 1'b1;
            cfg.index <= head.idx;
            cfg.data <= head.data;
            src_idle_en = head.src_idle;
            sink_idle_en = head.sink_idle;
          end else begin
            cfg.valid <= 1'b0;
          end
        end else begin
          head = pend_items.pop_front();
          pixel.valid <= 1'b1;
          pixel.pixel_value <= head.pix;
          cfg.valid <= 1'b0;
          src_gap = next_gap(src_idle_en);
        end
      end
    end
  end

  // Monitor: checks each accepted word against the oldest expected one.
  always @(posedge clk) begin : observe
    pad_word_t want;
    if (rst) begin
      result.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (result.valid && result.ready) begin
        words_checked++;
        if (due_words.size() == 0) begin
          $error("unexpected word: out_x %0d out_y %0d out_value %0d", result.out_x,
                 result.out_y, result.out_value);
          err_count++;
        end else begin
          want = due_words.pop_front();
          if (result.out_x !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, result.out_x);
            err_count++;
          end
          if (result.out_y !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, result.out_y);
            err_count++;
          end
          if (result.out_value !== want.value) begin
            $error("out_value: expected %0d, got %0d", want.value, result.out_value);
            err_count++;
          end
          if (result.run_last !== want.last) begin
            $error("run_last: expected %0d, got %0d", want.last, result.run_last);
            err_count++;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        sink_gap = next_gap(sink_idle_en);
      end
    end
  end

  // Watchdog: give up when no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (pixel.valid && pixel.ready) || (cfg.valid && cfg.ready) ||
        (result.valid && result.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int w_data, h_data, b_data, eff_w, eff_h, npix, split;
    bit si, ki;
    rst = 1'b1;
    pixel.valid = 1'b0;
    pixel.pixel_value = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_FRAME_WIDTH;
    cfg.data = '0;
    result.ready = 1'b0;
    geo_w = DIM_W'(352);
    geo_h = DIM_W'(288);
    geo_b = BORDER_W'(4);
    col_pos = 0;
    row_pos = 0;

    // Reset geometry: top-left corner, then pixels along the top edge.
    add_pixel(16'sh8000);
    add_pixel(16'sh7FFF);
    add_pixel(16'sh0000);
    add_pixel(-16'sd1);

    // Smallest frame with the widest border: every pixel is a corner.
    add_cfg(CFG_FRAME_WIDTH, DIM_W'(2), 1'b1, 1'b1);
    add_cfg(CFG_FRAME_HEIGHT, DIM_W'(2), 1'b1, 1'b1);
    add_cfg(CFG_BORDER_WIDTH, DIM_W'(7), 1'b1, 1'b1);
    add_pixel(16'sh5555);
    add_pixel(16'shAAAA);
    add_pixel(16'sh0001);
    add_pixel(16'sh8000);

    // Undersized dimensions saturate to two, no border; the last pixel wraps.
    add_cfg(CFG_FRAME_WIDTH, DIM_W'(0), 1'b0, 1'b0);
    add_cfg(CFG_FRAME_HEIGHT, DIM_W'(1), 1'b0, 1'b0);
    add_cfg(CFG_BORDER_WIDTH, DIM_W'(0), 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) begin
      add_pixel(PIX_W'($urandom()));
    end

    // Oversized dimensions saturate to the maximum; border from low data bits.
    add_cfg(CFG_FRAME_WIDTH, DIM_W'(32767), 1'b1, 1'b0);
    add_cfg(CFG_FRAME_HEIGHT, DIM_W'(32767), 1'b1, 1'b0);
    add_cfg(CFG_BORDER_WIDTH, DIM_W'(32765), 1'b1, 1'b0);
    for (int i = 0; i < 3; i++) begin
      add_pixel(PIX_W'($urandom()));
    end

    // A write to the unused index must not restart the frame.
    add_cfg(CFG_FRAME_WIDTH, DIM_W'(3), 1'b0, 1'b1);
    add_cfg(CFG_FRAME_HEIGHT, DIM_W'(3), 1'b0, 1'b1);
    add_cfg(CFG_BORDER_WIDTH, DIM_W'(1), 1'b0, 1'b1);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) begin
        add_cfg(CFG_NONE, DIM_W'(32767), 1'b0, 1'b1);
      end
      add_pixel(PIX_W'($urandom()));
    end

    // Random geometries, mostly small frames sent whole, some huge ones cut short.
    while (pixels_queued < PIXEL_TARGET) begin
      si = ($urandom_range(0, 4) != 0) && ($urandom_range(0, 3) != 0);
      ki = ($urandom_range(0, 4) != 0) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: w_data = $urandom_range(0, 32767);
        1: w_data = $urandom_range(0, 1);
        default: w_data = $urandom_range(2, 9);
      endcase
      case ($urandom_range(0, 9))
        0: h_data = $urandom_range(0, 32767);
        1: h_data = $urandom_range(0, 1);
        default: h_data = $urandom_range(2, 6);
      endcase
      b_data = $urandom_range(0, 32767);
      add_cfg(CFG_FRAME_WIDTH, DIM_W'(w_data), si, ki);
      add_cfg(CFG_FRAME_HEIGHT, DIM_W'(h_data), si, ki);
      add_cfg(CFG_BORDER_WIDTH, DIM_W'(b_data), si, ki);
      eff_w = (w_data < MinDim) ? MinDim : (w_data > MaxWidth) ? MaxWidth : w_data;
      eff_h = (h_data < MinDim) ? MinDim : (h_data > MaxHeight) ? MaxHeight : h_data;
      if (eff_w * eff_h <= 120) begin
        npix = eff_w * eff_h * $urandom_range(1, 2) + $urandom_range(0, eff_w);
      end else begin
        npix = $urandom_range(5, 40);
      end
      // The last frame is cut short so the pixel total lands on the target.
      if (npix > PIXEL_TARGET - pixels_queued) begin
        npix = PIXEL_TARGET - pixels_queued;
      end
      split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, npix - 1) : -1;
      for (int i = 0; i < npix; i++) begin
        if (i == split) begin
          add_cfg(CFG_NONE, DIM_W'($urandom_range(0, 32767)), si, ki);
        end
        add_pixel(PIX_W'($urandom()));
      end
      phases++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (items_done != items_total) begin
      @(posedge clk);
    end
    while (due_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d pixels over %0d random geometries plus directed corners,",
             pixels_queued, phases);
    $display("summary: %0d padded words checked, %0d mismatches", words_checked, err_count);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
